// File: src/decimal_bignum_subtractor_macros.svh
// Assertion helpers for the decimal subtractor.
`ifndef DECIMAL_BIGNUM_SUBTRACTOR_MACROS_SVH
`define DECIMAL_BIGNUM_SUBTRACTOR_MACROS_SVH
`ifndef SYNTH
`define DBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define DBS_ASSERT_IMP(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define DBS_ASSERT(lbl, clk, rst, prop, msg)
`define DBS_ASSERT_IMP(lbl, clk, rst, pre, post, msg)
`endif
`endif

// File: src/dbs_pkg.sv
`default_nettype none
package dbs_pkg;

   localparam int MAX_DIGITS_DEF = 32;
   localparam int DIGIT_W = 4;
   localparam logic [DIGIT_W-1:0] DIGIT_MAX = 4'd9;
   localparam logic [DIGIT_W:0] RADIX = 5'd10;

   typedef struct packed {
      logic clear;
      logic cmp_en;
      logic sub_en;
   } dbs_ctl_type;

endpackage
`default_nettype wire

// File: src/dbs_digit_unit.sv
`default_nettype none
// One digit per cycle: magnitude compare (most significant first), then
// decimal subtract of larger minus smaller (least significant first).
module dbs_digit_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dbs_pkg::dbs_ctl_type           ctl,
   input  wire logic [dbs_pkg::DIGIT_W-1:0]    x,
   input  wire logic [dbs_pkg::DIGIT_W-1:0]    y,
   output logic                                neg,
   output logic [dbs_pkg::DIGIT_W-1:0]         diff
);

   logic decided_ff, decided_in;
   logic neg_ff, neg_in;
   logic borrow_ff, borrow_in;

   logic [dbs_pkg::DIGIT_W:0] hi;
   logic [dbs_pkg::DIGIT_W:0] lo;
   logic [dbs_pkg::DIGIT_W:0] diff_wide;
   logic                      under;

   always_comb begin
      hi = {1'b0, (neg_ff ? y : x)};
      lo = {1'b0, (neg_ff ? x : y)} + {{dbs_pkg::DIGIT_W{1'b0}}, borrow_ff};
      under = hi < lo;
      diff_wide = under ? (hi + dbs_pkg::RADIX - lo) : (hi - lo);
      diff = diff_wide[dbs_pkg::DIGIT_W-1:0];
      neg = neg_ff;
   end

   always_comb begin
      decided_in = decided_ff;
      neg_in = neg_ff;
      borrow_in = borrow_ff;
      if (ctl.clear) begin
         decided_in = 1'b0;
         neg_in = 1'b0;
         borrow_in = 1'b0;
      end else begin
         // first differing digit settles the sign
         if (ctl.cmp_en && !decided_ff && (x != y)) begin
            decided_in = 1'b1;
            neg_in = x < y;
         end
         if (ctl.sub_en) begin
            borrow_in = under;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decided_ff <= 1'b0;
         neg_ff <= 1'b0;
         borrow_ff <= 1'b0;
      end else begin
         decided_ff <= decided_in;
         neg_ff <= neg_in;
         borrow_ff <= borrow_in;
      end
   end

endmodule
`default_nettype wire

// File: src/decimal_bignum_subtractor.sv
// Decimal subtractor for two unsigned numbers sent as digit streams.
// req channel: one beat per digit, most significant first. tuser selects the
// operand (0 minuend, 1 subtrahend), tlast marks an operand's final digit.
// Beats are taken one per cycle while loading; the subtrahend's last beat
// starts the run. n = longer operand length (at least 1).
// The compare pass walks the digit stores, then the subtract pass, then n
// result beats follow; each result digit is read through the result store's
// registered read port and reaches the output register before the next read.
// rsp channel: tdata carries the digit, tuser the negative flag (same on
// every beat of a run), tlast the final digit. A stalled receiver holds the
// output register and pauses the readout; req_tready stays low from the
// run's start until the last result is read from the store.
// Digits beyond MAX_DIGITS per operand are dropped; digit codes above nine
// count as nine. Reset empties both operands and drops any pending result.
`default_nettype none
`include "decimal_bignum_subtractor_macros.svh"
module decimal_bignum_subtractor #(
   parameter int MAX_DIGITS = dbs_pkg::MAX_DIGITS_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [3:0] digit, [7:4] zero
   input  wire logic       req_tuser,   // [0] mode
   input  wire logic       req_tlast,
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [3:0] result_digit, [7:4] zero
   output logic            rsp_tuser,   // [0] negative
   output logic            rsp_tlast
);

   localparam int LEN_W = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);
   localparam int W = dbs_pkg::DIGIT_W;
   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_DIGITS);
   localparam logic [LEN_W-1:0] ONE = LEN_W'(1);

   localparam logic [1:0] S_LOAD = 2'd0;
   localparam logic [1:0] S_CMP  = 2'd1;
   localparam logic [1:0] S_SUB  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [LEN_W-1:0] cnt_ff, cnt_in;
   logic [LEN_W-1:0] n_ff, n_in;
   logic [LEN_W-1:0] ml_ff, ml_in;
   logic [LEN_W-1:0] sl_ff, sl_in;
   logic             mdone_ff, mdone_in;

   logic [W-1:0] mstore [MAX_DIGITS];
   logic [W-1:0] sstore [MAX_DIGITS];
   logic [W-1:0] rstore [MAX_DIGITS];

   logic [W-1:0]      m_rd_ff, s_rd_ff, r_rd_ff;
   logic              vld_ff, m_hit_ff, s_hit_ff;
   logic [ADDR_W-1:0] pos_ff;
   logic              pend_ff, pend_last_ff;
   logic              out_vld_ff, out_vld_in;
   logic [W-1:0]      out_digit_ff;
   logic              out_neg_ff, out_last_ff;

   logic             accept;
   logic [W-1:0]     digit_sat;
   logic             m_we, s_we;
   logic [LEN_W-1:0] sl_next, run_len;
   logic             issue, e_issue, pass_end;
   logic [LEN_W-1:0] pos, m_addr, s_addr, e_addr;
   logic             m_hit, s_hit;

   dbs_pkg::dbs_ctl_type ctl;
   logic [W-1:0] x, y, diff;
   logic         neg;

   assign req_tready = (state_ff == S_LOAD);
   assign accept = req_tvalid && req_tready;
   assign digit_sat = (req_tdata[W-1:0] > dbs_pkg::DIGIT_MAX) ?
                      dbs_pkg::DIGIT_MAX : req_tdata[W-1:0];

   assign m_we = accept && !req_tuser && !mdone_ff && (ml_ff < MAX_LEN);
   assign s_we = accept && req_tuser && (sl_ff < MAX_LEN);
   assign sl_next = sl_ff + {{(LEN_W-1){1'b0}}, s_we};
   assign run_len = (ml_ff > sl_next) ? ml_ff : sl_next;

   // digit walk: compare goes from the top position down, subtract from units up
   assign pass_end = (cnt_ff == n_ff);
   assign issue = ((state_ff == S_CMP) || (state_ff == S_SUB)) && !pass_end;
   assign pos = (state_ff == S_CMP) ? (n_ff - ONE - cnt_ff) : cnt_ff;
   assign m_hit = pos < ml_ff;
   assign s_hit = pos < sl_ff;
   assign m_addr = ml_ff - ONE - pos;
   assign s_addr = sl_ff - ONE - pos;

   assign e_issue = (state_ff == S_EMIT) && !pass_end && !pend_ff &&
                    (!out_vld_ff || rsp_tready);
   assign e_addr = n_ff - ONE - cnt_ff;

   assign x = m_hit_ff ? m_rd_ff : '0;
   assign y = s_hit_ff ? s_rd_ff : '0;

   always_comb begin
      ctl.clear = (state_ff == S_LOAD);
      ctl.cmp_en = vld_ff && (state_ff == S_CMP);
      ctl.sub_en = vld_ff && (state_ff == S_SUB);
   end

   dbs_digit_unit u_unit (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .x     (x),
      .y     (y),
      .neg   (neg),
      .diff  (diff)
   );

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      n_in = n_ff;
      ml_in = ml_ff;
      sl_in = sl_ff;
      mdone_in = mdone_ff;
      case (state_ff)
         S_LOAD: begin
            ml_in = ml_ff + {{(LEN_W-1){1'b0}}, m_we};
            sl_in = sl_next;
            if (accept && !req_tuser && req_tlast) begin
               mdone_in = 1'b1;
            end
            if (accept && req_tuser && req_tlast) begin
               state_in = S_CMP;
               cnt_in = '0;
               n_in = (run_len == '0) ? ONE : run_len;
            end
         end
         S_CMP, S_SUB: begin
            if (pass_end) begin
               state_in = (state_ff == S_CMP) ? S_SUB : S_EMIT;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_ff + ONE;
            end
         end
         S_EMIT: begin
            if (e_issue) begin
               cnt_in = cnt_ff + ONE;
            end
            if (pass_end && !pend_ff) begin
               state_in = S_LOAD;
               cnt_in = '0;
               ml_in = '0;
               sl_in = '0;
               mdone_in = 1'b0;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      if (pend_ff) begin
         out_vld_in = 1'b1;
      end else if (out_vld_ff && rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         cnt_ff <= '0;
         n_ff <= ONE;
         ml_ff <= '0;
         sl_ff <= '0;
         mdone_ff <= 1'b0;
         vld_ff <= 1'b0;
         pend_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         n_ff <= n_in;
         ml_ff <= ml_in;
         sl_ff <= sl_in;
         mdone_ff <= mdone_in;
         vld_ff <= issue;
         pend_ff <= e_issue;
         out_vld_ff <= out_vld_in;
      end
   end

   // operand stores
   always_ff @(posedge clock) begin
      if (m_we) begin
         mstore[ml_ff[ADDR_W-1:0]] <= digit_sat;
      end
      if (issue) begin
         m_rd_ff <= mstore[m_addr[ADDR_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         sstore[sl_ff[ADDR_W-1:0]] <= digit_sat;
      end
      if (issue) begin
         s_rd_ff <= sstore[s_addr[ADDR_W-1:0]];
      end
   end

   // result store, written units first, read back most significant first
   always_ff @(posedge clock) begin
      if (ctl.sub_en) begin
         rstore[pos_ff] <= diff;
      end
      if (e_issue) begin
         r_rd_ff <= rstore[e_addr[ADDR_W-1:0]];
         pend_last_ff <= (cnt_ff + ONE) == n_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         m_hit_ff <= m_hit;
         s_hit_ff <= s_hit;
         pos_ff <= pos[ADDR_W-1:0];
      end
      if (pend_ff) begin
         out_digit_ff <= r_rd_ff;
         out_neg_ff <= neg;
         out_last_ff <= pend_last_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata = {{(8-W){1'b0}}, out_digit_ff};
   assign rsp_tuser = out_neg_ff;
   assign rsp_tlast = out_last_ff;

   `DBS_ASSERT(a_len_cap, clock, reset, (ml_ff <= MAX_LEN) && (sl_ff <= MAX_LEN), "length over cap")
   `DBS_ASSERT_IMP(a_pend_slot, clock, reset, pend_ff, !out_vld_ff, "readout hit a full output")
   `DBS_ASSERT_IMP(a_sign_hold, clock, reset, state_ff == S_EMIT, $stable(neg), "sign moved in readout")

endmodule
`default_nettype wire

// File: verif/tb_decimal_bignum_subtractor.sv
`timescale 1ns / 1ps

module tb_decimal_bignum_subtractor;

   localparam int MAX_DIGITS = dbs_pkg::MAX_DIGITS_DEF;
   localparam logic MODE_MINUEND = 1'b0;
   localparam logic MODE_SUBTRAHEND = 1'b1;
   localparam int ITEM_TARGET = 260;
   localparam int TAIL_BEATS = 40;
   localparam int SETTLE_CYCLES = 200;
   localparam int TIMEOUT_NS = 3_000_000;

   typedef struct {
      logic       mode;
      logic [3:0] digit;
      logic       last;
      bit         drain_first;
   } digit_beat_type;

   typedef struct {
      logic [7:0] tdata;
      logic       negative;
      logic       last;
   } diff_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = '0;  // [3:0] digit, [7:4] zero
   logic       req_tuser = 1'b0; // [0] mode
   logic       req_tlast = 1'b0;
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;       // [3:0] result_digit, [7:4] zero
   logic       rsp_tuser;       // [0] negative
   logic       rsp_tlast;

   decimal_bignum_subtractor uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   digit_beat_type pending_beats[$];
   diff_beat_type  expected_diffs[$];
   logic [3:0]     minuend_src[$];
   logic [3:0]     subtrahend_src[$];

   // predictor state
   logic [3:0] held_minuend [MAX_DIGITS];
   logic [3:0] held_subtrahend [MAX_DIGITS];
   int         minuend_count = 0;
   int         subtrahend_count = 0;
   bit         minuend_closed = 1'b0;

   int mismatch_total = 0;
   int idle_left = 0;
   int stall_left = 0;
   int stall_pct = 0;
   int stall_phase_left = 0;
   bit quiet_tail = 1'b0;

   task automatic log_failure(input string what);
      mismatch_total++;
      if (mismatch_total <= 10) $display("%0t: %s", $time, what);
   endtask

   // digit at weight position pos (0 = units), zero beyond the operand's length
   function automatic int operand_digit(input logic which, input int pos);
      int d;
      d = 0;
      if (which == MODE_MINUEND) begin
         if (pos < minuend_count) d = int'(held_minuend[minuend_count - 1 - pos]);
      end else begin
         if (pos < subtrahend_count) d = int'(held_subtrahend[subtrahend_count - 1 - pos]);
      end
      return d;
   endfunction

   task automatic absorb_digit(input logic mode, input logic [3:0] raw, input logic last);
      logic [3:0] d;
      logic [3:0] diff [MAX_DIGITS];
      int         span, pos, cmp, borrow, x, y, top, sub;
      bit         neg;
      diff_beat_type r;
      d = (raw > dbs_pkg::DIGIT_MAX) ? dbs_pkg::DIGIT_MAX : raw;
      if (mode == MODE_MINUEND) begin
         if (!minuend_closed) begin
            if (minuend_count < MAX_DIGITS) begin
               held_minuend[minuend_count] = d;
               minuend_count++;
            end
            if (last) minuend_closed = 1'b1;
         end
      end else begin
         if (subtrahend_count < MAX_DIGITS) begin
            held_subtrahend[subtrahend_count] = d;
            subtrahend_count++;
         end
         if (last) begin
            span = (minuend_count > subtrahend_count) ? minuend_count : subtrahend_count;
            if (span == 0) span = 1;
            cmp = 0;
            for (pos = span - 1; pos >= 0 && cmp == 0; pos--) begin
               x = operand_digit(MODE_MINUEND, pos);
               y = operand_digit(MODE_SUBTRAHEND, pos);
               if (x > y) cmp = 1;
               else if (x < y) cmp = -1;
            end
            neg = (cmp < 0);
            borrow = 0;
            for (pos = 0; pos < span; pos++) begin
               x = operand_digit(MODE_MINUEND, pos);
               y = operand_digit(MODE_SUBTRAHEND, pos);
               top = neg ? y : x;
               sub = (neg ? x : y) + borrow;
               if (top < sub) begin
                  diff[pos] = 4'(top + int'(dbs_pkg::RADIX) - sub);
                  borrow = 1;
               end else begin
                  diff[pos] = 4'(top - sub);
                  borrow = 0;
               end
            end
            for (pos = span - 1; pos >= 0; pos--) begin
               r.tdata = {4'b0000, diff[pos]};
               r.negative = neg;
               r.last = (pos == 0);
               expected_diffs.push_back(r);
            end
            minuend_count = 0;
            subtrahend_count = 0;
            minuend_closed = 1'b0;
         end
      end
   endtask

   task automatic push_beat(input logic mode, input logic [3:0] digit, input logic last,
                            input bit drain_first);
      digit_beat_type b;
      b.mode = mode;
      b.digit = digit;
      b.last = last;
      b.drain_first = drain_first;
      pending_beats.push_back(b);
   endtask

   task automatic fill_operand(input logic which, input int len, input int hi);
      repeat (len) begin
         if (which == MODE_MINUEND) minuend_src.push_back(4'($urandom_range(0, hi)));
         else subtrahend_src.push_back(4'($urandom_range(0, hi)));
      end
   endtask

   // sends both source operands; the subtrahend's last digit always goes out last
   task automatic emit_run(input bit mix, input bit mark_mlast, input int noise,
                           input bit drain);
      int mi, si, ms, ss;
      bit lead;
      mi = 0;
      si = 0;
      lead = drain;
      ms = minuend_src.size();
      ss = subtrahend_src.size();
      while (mi < ms || si < ss - 1) begin
         if (mi < ms && (si >= ss - 1 || !mix || $urandom_range(0, 1) == 1)) begin
            push_beat(MODE_MINUEND, minuend_src[mi], mark_mlast && (mi == ms - 1), lead);
            mi++;
         end else begin
            push_beat(MODE_SUBTRAHEND, subtrahend_src[si], 1'b0, lead);
            si++;
         end
         lead = 1'b0;
      end
      // extra minuend beats: dropped once the minuend is closed, else appended
      repeat (noise) begin
         push_beat(MODE_MINUEND, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), lead);
         lead = 1'b0;
      end
      push_beat(MODE_SUBTRAHEND, subtrahend_src[ss - 1], 1'b1, lead);
   endtask

   // sender
   always @(posedge clock) begin : drive_proc
      digit_beat_type nxt;
      bit send;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) absorb_digit(req_tuser, req_tdata[3:0], req_tlast);
         if (!(req_tvalid && !req_tready)) begin
            send = 1'b0;
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_beats.size() > 0) begin
               if (pending_beats[0].drain_first && expected_diffs.size() > 0) begin
                  // hold off until the block has handed over every result
               end else if (pending_beats.size() >= TAIL_BEATS &&
                            $urandom_range(0, 99) < ((pending_beats.size() / 40) % 3) * 20) begin
                  idle_left = $urandom_range(1, 5) - 1;
               end else begin
                  nxt = pending_beats.pop_front();
                  send = 1'b1;
               end
            end
            req_tvalid <= send;
            if (send) begin
               req_tdata <= {4'b0000, nxt.digit};
               req_tuser <= nxt.mode;
               req_tlast <= nxt.last;
            end
         end
         quiet_tail <= (pending_beats.size() < TAIL_BEATS);
      end
   end

   // receiver and checker
   always @(posedge clock) begin : check_proc
      diff_beat_type want;
      bit ready;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_diffs.size() == 0) begin
               log_failure($sformatf("unexpected result beat: tdata=%h tuser=%b tlast=%b",
                                     rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = expected_diffs.pop_front();
               if (rsp_tdata !== want.tdata)
                  log_failure($sformatf("rsp_tdata: expected %h, got %h",
                                        want.tdata, rsp_tdata));
               if (rsp_tuser !== want.negative)
                  log_failure($sformatf("rsp_tuser (negative): expected %b, got %b",
                                        want.negative, rsp_tuser));
               if (rsp_tlast !== want.last)
                  log_failure($sformatf("rsp_tlast: expected %b, got %b",
                                        want.last, rsp_tlast));
            end
         end
         if (stall_phase_left > 0) begin
            stall_phase_left--;
         end else begin
            stall_phase_left = $urandom_range(50, 300);
            case ($urandom_range(0, 2))
               0: stall_pct = 0;
               1: stall_pct = 15;
               default: stall_pct = 40;
            endcase
         end
         ready = 1'b1;
         if (stall_left > 0) begin
            stall_left--;
            ready = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 5) - 1;
            ready = 1'b0;
         end
         rsp_tready <= ready;
      end
   end

   initial begin : timeout_proc
      #(TIMEOUT_NS);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin : stimulus_proc
      int mlen, slen, hi, kind, pos;
      bit wide;

      // empty minuend
      push_beat(MODE_SUBTRAHEND, 4'd5, 1'b1, 1'b0);
      // equal operands
      push_beat(MODE_MINUEND, 4'd1, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd2, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd1, 1'b0, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd2, 1'b1, 1'b0);
      // same length, first differing digit says minuend is smaller
      push_beat(MODE_MINUEND, 4'd1, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd9, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd2, 1'b0, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd3, 1'b1, 1'b0);
      // longer operand wins, borrow ripples through zeros
      push_beat(MODE_MINUEND, 4'd1, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd0, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd0, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd9, 1'b0, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd9, 1'b1, 1'b0);
      // digit codes above nine count as nine
      push_beat(MODE_MINUEND, 4'd15, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd10, 1'b1, 1'b0);
      // subtrahend ahead of minuend, minuend beats after its last ignored
      push_beat(MODE_SUBTRAHEND, 4'd3, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd4, 1'b1, 1'b0);
      push_beat(MODE_MINUEND, 4'd7, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd8, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd1, 1'b1, 1'b0);
      // leading zeros on an equal value
      push_beat(MODE_MINUEND, 4'd0, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd0, 1'b0, 1'b0);
      push_beat(MODE_MINUEND, 4'd7, 1'b1, 1'b0);
      push_beat(MODE_SUBTRAHEND, 4'd7, 1'b1, 1'b0);

      // both stores full, minuend smaller, no digit borrows; sender waits for the block to drain first
      minuend_src.delete();
      subtrahend_src.delete();
      repeat (MAX_DIGITS) minuend_src.push_back(4'd0);
      repeat (MAX_DIGITS) subtrahend_src.push_back(4'd9);
      emit_run(1'b0, 1'b1, 0, 1'b1);
      // both operands past capacity
      minuend_src.delete();
      subtrahend_src.delete();
      fill_operand(MODE_MINUEND, MAX_DIGITS + 3, 9);
      fill_operand(MODE_SUBTRAHEND, MAX_DIGITS + 1, 15);
      emit_run(1'b1, 1'b1, 0, 1'b0);

      while (pending_beats.size() < ITEM_TARGET) begin
         minuend_src.delete();
         subtrahend_src.delete();
         wide = ($urandom_range(0, 15) == 0);
         mlen = wide ? $urandom_range(20, MAX_DIGITS + 3) : $urandom_range(0, 6);
         slen = wide ? $urandom_range(20, MAX_DIGITS + 3) : $urandom_range(1, 6);
         hi = ($urandom_range(0, 7) == 0) ? 15 : 9;
         kind = $urandom_range(0, 9);
         fill_operand(MODE_MINUEND, mlen, hi);
         if (kind <= 4) begin
            fill_operand(MODE_SUBTRAHEND, slen, hi);
         end else if (kind <= 7) begin
            subtrahend_src = minuend_src;
            if (kind == 7 && subtrahend_src.size() > 0) begin
               pos = $urandom_range(0, subtrahend_src.size() - 1);
               subtrahend_src[pos] = 4'((subtrahend_src[pos] + $urandom_range(1, 9)) % 10);
            end
         end else if (kind == 8) begin
            subtrahend_src = minuend_src;
            repeat ($urandom_range(1, 3)) subtrahend_src.push_front(4'd0);
            if ($urandom_range(0, 1) == 1) begin
               minuend_src = subtrahend_src;
               subtrahend_src.delete();
               fill_operand(MODE_SUBTRAHEND, slen, 9);
            end
         end else begin
            // one followed by zeros: long borrow chain
            minuend_src.delete();
            minuend_src.push_back(4'd1);
            repeat (mlen) minuend_src.push_back(4'd0);
            fill_operand(MODE_SUBTRAHEND, $urandom_range(1, 3), 9);
         end
         if (subtrahend_src.size() == 0) subtrahend_src.push_back(4'($urandom_range(0, 9)));
         emit_run($urandom_range(0, 3) == 0, $urandom_range(0, 9) != 0,
                  ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0,
                  $urandom_range(0, 9) == 0);
      end

      @(posedge clock);
      while (reset || pending_beats.size() > 0 || req_tvalid || expected_diffs.size() > 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_diffs.size() > 0)
         log_failure($sformatf("%0d result beats never arrived", expected_diffs.size()));
      if (mismatch_total == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin : reset_proc
      reset = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
